>>> rtl/core/mha_pkg.sv
// Shared types, operation codes and constants of the high-pass and gain control block.
package mha_pkg;

    // One input word.
    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               chunk_first;
        logic               chunk_last;
        logic [10:0]        chunk_length;
        logic               mute_chunk;
        logic               restart_filter;
    } t_in_word;

    // One output word.
    typedef struct packed {
        logic signed [15:0] sample_out;
        logic [15:0]        gain_now;
        logic [15:0]        raw_peak_out;
        logic               silence_flag;
    } t_out_word;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHPASS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PEAK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_THR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_HOLD  = 3'd6;

    // Datapath operation codes issued by the controller.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
    localparam logic [OP_W-1:0] OP_FIRST_GO   = 4'd2;
    localparam logic [OP_W-1:0] OP_FIRST_DONE = 4'd3;
    localparam logic [OP_W-1:0] OP_HP_MUL     = 4'd4;
    localparam logic [OP_W-1:0] OP_HP_GO      = 4'd5;
    localparam logic [OP_W-1:0] OP_HP_SUM     = 4'd6;
    localparam logic [OP_W-1:0] OP_GATE       = 4'd7;
    localparam logic [OP_W-1:0] OP_G_MUL      = 4'd8;
    localparam logic [OP_W-1:0] OP_G_GO       = 4'd9;
    localparam logic [OP_W-1:0] OP_G_OUT      = 4'd10;
    localparam logic [OP_W-1:0] OP_LAST       = 4'd11;
    localparam logic [OP_W-1:0] OP_T_GO       = 4'd12;
    localparam logic [OP_W-1:0] OP_T_DONE     = 4'd13;
    localparam logic [OP_W-1:0] OP_OUT        = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic bypass;
        logic first;
        logic last;
        logic mute;
        logic div_busy;
        logic tdiv_need;
    } t_stat;

    // Divider geometry.
    localparam int DIV_W = 48;
    localparam int DVS_W = 16;
    localparam int DCNT_W = $clog2(DIV_W);

    // Peak decay: 32767 * len * 2 / (16000 * 3), taken as a multiply by the
    // rounded-up reciprocal of 24000 / 32767 and a 32-bit shift. This is exact
    // for every length up to 1024.
    localparam int DECAY_SH = 32;
    localparam logic [32:0] DECAY_MUL =
        33'(((64'd1 << DECAY_SH) * 64'd32767 + 64'd23999) / 64'd24000);

    // Register and gain reset values.
    localparam logic [15:0] GAIN_RESET       = 16'd12288;
    localparam logic [14:0] TARGET_PEAK_RST  = 15'd24575;
    localparam logic [14:0] QUIET_THR_RST    = 15'd65;
    localparam logic [15:0] QUIET_HOLD_RST   = 16'd8000;

endpackage

>>> rtl/core/mic_highpass_agc_top.sv
// Top level of the microphone high-pass filter with automatic gain control.
//
// The block takes one 16-bit microphone sample per input word, passes it
// through a DC-blocking first-order high-pass, a silence gate and a gain
// multiply with 16-bit saturation, and returns one output word per input
// word. At the first sample of a chunk the held peaks decay by an amount
// set by the chunk length; at the last sample the chunk peaks merge and the
// gain slews toward a new target (automatic, fixed, or zero under silence).
// When GAIN_ONE is a power of two, a word goes from acceptance to its output
// register through two registered multiplies plus the filter, gate, scaling
// and output steps, followed by a return to idle. A word in bypass skips the
// filter, gate and gain steps. The first word of a chunk adds a restart step
// and the peak decay, which uses a reciprocal multiply. The last word adds
// the merge, target and slew steps (only the chunk-end step when muted) and
// a wait when the automatic target needs its division, done in a radix-2
// divider that produces a quotient bit per cycle over 48 bits. If GAIN_ONE
// is not a power of two, the filter and gain scaling also go through that
// divider. The next word is accepted as soon as the current one reaches the
// output register, even if that word has not been taken yet. Configuration
// is written through a plain write port; the user must write only while no
// word is in flight, which the block does not enforce. Bypass, high-pass and
// fixed-gain writes take effect at once. There is no clearing pass.
module mic_highpass_agc_top #(
    parameter int GAIN_ONE  = 8192,
    parameter int MAX_CHUNK = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mha_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mha_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_we,
    input  logic [mha_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_data
);
    import mha_pkg::*;

    // Command and status between the controller and the datapath.
    t_cmd  cmd;
    t_stat stat;

    mha_ctrl #(
        .GAIN_ONE (GAIN_ONE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the registers, filter state, gain state and the
    // shared divider; it acts on the operation the controller issues and on configuration writes.
    mha_datapath #(
        .GAIN_ONE  (GAIN_ONE),
        .MAX_CHUNK (MAX_CHUNK)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_word (o_out_word)
    );

endmodule

>>> rtl/core/mha_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module mha_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mha_pkg::DIV_W-1:0] i_dividend,
    input  logic [mha_pkg::DVS_W-1:0] i_divisor,
    output logic [mha_pkg::DIV_W-1:0] o_quotient,
    output logic                      o_busy
);
    import mha_pkg::*;

    logic              r_busy;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVS_W:0]    r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {r_rem[DVS_W-1:0], r_quo[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(DIV_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

>>> rtl/core/mha_datapath.sv
// Datapath: configuration, filter, silence gate, gain multiply and chunk-end gain update.
module mha_datapath #(
    parameter int GAIN_ONE  = 8192,
    parameter int MAX_CHUNK = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mha_pkg::t_in_word                 i_in_word,
    input  logic                              i_cfg_we,
    input  logic [mha_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [15:0]                       i_cfg_data,
    input  mha_pkg::t_cmd                     i_cmd,
    output mha_pkg::t_stat                    o_stat,
    output mha_pkg::t_out_word                o_out_word
);
    import mha_pkg::*;

    localparam int GL        = $clog2(GAIN_ONE);
    localparam bit POW2      = (GAIN_ONE == (1 << GL));
    localparam int GMAX      = 5 * GAIN_ONE;
    localparam int GW        = ($clog2(GMAX + 1) > 16) ? $clog2(GMAX + 1) : 16;
    localparam int HP_COEF   = (8151 * GAIN_ONE) / 8192;
    localparam int STEP_UNIT = GAIN_ONE / 128;
    localparam int STEP_UP   = STEP_UNIT * 3;
    localparam int STEP_DOWN = STEP_UNIT * 8;

    // Configuration.
    logic        r_bypass, r_hp_on, r_fixed;
    logic [15:0] r_fixed_gain;
    logic [14:0] r_tpl, r_qthr;
    logic [15:0] r_qhold;

    // Algorithm state.
    t_in_word           r_in;
    logic signed [15:0] r_prev_in;
    logic signed [31:0] r_prev_out;
    logic               r_primed;
    logic signed [15:0] r_lf;
    logic               r_lfv;
    logic [16:0]        r_qcnt;
    logic               r_sil;
    logic [15:0]        r_raw, r_scaled, r_craw, r_cscaled;
    logic [GW-1:0]      r_active, r_previous, r_current, r_target;
    logic               r_switched;

    // Working registers.
    logic [DIV_W-1:0]   r_prod;
    logic signed [15:0] r_f;
    logic signed [15:0] r_y;
    t_out_word          r_out;

    // Divider hookup.
    logic             div_go, div_busy;
    logic [DIV_W-1:0] div_a, div_q;
    logic [DVS_W-1:0] div_b;

    mha_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_quotient (div_q),
        .o_busy     (div_busy)
    );

    logic [12:0] len_c;
    assign len_c = (13'(r_in.chunk_length) > 13'(MAX_CHUNK)) ? 13'(MAX_CHUNK)
                                                             : 13'(r_in.chunk_length);

    always_comb begin
        div_go = 1'b0;
        div_a  = r_prod;
        div_b  = DVS_W'(GAIN_ONE);
        unique case (i_cmd.op) inside
            OP_HP_GO, OP_G_GO: begin
                div_go = 1'b1;
            end
            OP_T_GO: begin
                div_go = 1'b1;
                div_a  = DIV_W'(r_tpl) * DIV_W'(GAIN_ONE) + DIV_W'(r_raw >> 1);
                div_b  = r_raw;
            end
            default: begin
                div_go = 1'b0;
            end
        endcase
    end

    // Quotient by GAIN_ONE: a shift when it is a power of two.
    logic [DIV_W-1:0] q_sel;
    assign q_sel = POW2 ? (r_prod >> GL) : div_q;

    // Peak decay, at least one per chunk.
    logic [45:0] decay_p;
    logic [13:0] decay_q;
    logic [15:0] decay_d, raw_dec, scl_dec;
    assign decay_p = {33'b0, len_c} * {13'b0, DECAY_MUL};
    assign decay_q = decay_p[45:32];
    assign decay_d = (decay_q > 14'd1) ? {2'b0, decay_q} : 16'd1;
    assign raw_dec = (decay_d >= r_raw) ? 16'd0 : r_raw - decay_d;
    assign scl_dec = (decay_d >= r_scaled) ? 16'd0 : r_scaled - decay_d;

    // High-pass terms.
    logic               prev_sgn;
    logic [31:0]        prev_abs, hp_q;
    logic [47:0]        hp_mul;
    logic signed [34:0] hp_y, hp_qs;
    logic signed [31:0] hp_out32;
    logic signed [15:0] hp_out16;

    assign prev_sgn = r_prev_out[31];
    assign prev_abs = prev_sgn ? (~r_prev_out + 32'd1) : r_prev_out;
    assign hp_mul   = {16'b0, prev_abs} * {32'b0, 16'(HP_COEF)};
    assign hp_q     = q_sel[31:0];
    assign hp_qs    = prev_sgn ? -$signed({3'b0, hp_q}) : $signed({3'b0, hp_q});
    assign hp_y     = $signed({{19{r_in.sample_in[15]}}, r_in.sample_in})
                    - $signed({{19{r_prev_in[15]}}, r_prev_in}) + hp_qs;

    always_comb begin
        if (hp_y > 35'sd2147483647) begin
            hp_out32 = 32'sh7fffffff;
        end else if (hp_y < -35'sd2147483648) begin
            hp_out32 = 32'sh80000000;
        end else begin
            hp_out32 = hp_y[31:0];
        end
        if (hp_out32 > 32'sd32767) begin
            hp_out16 = 16'sh7fff;
        end else if (hp_out32 < -32'sd32768) begin
            hp_out16 = 16'sh8000;
        end else begin
            hp_out16 = hp_out32[15:0];
        end
    end

    // Gate, crossing and gain terms.
    logic [15:0]        f_abs;
    logic [16:0]        q_next;
    logic               crossed;
    logic [GW+15:0]     g_mul;
    logic signed [15:0] g_y;
    logic [15:0]        g_abs;

    assign f_abs   = r_f[15] ? (~r_f + 16'd1) : r_f;
    assign q_next  = (r_qcnt <= {1'b0, r_qhold}) ? r_qcnt + 17'd1 : r_qcnt;
    assign crossed = (r_f == 16'sd0) ||
                     (r_lfv && (((r_lf < 16'sd0) && (r_f > 16'sd0)) ||
                                ((r_lf > 16'sd0) && (r_f < 16'sd0))));
    assign g_mul   = {{GW{1'b0}}, f_abs} * {16'b0, r_active};

    always_comb begin
        if (!r_f[15]) begin
            if (q_sel > DIV_W'(32767)) begin
                g_abs = 16'd32767;
            end else begin
                g_abs = q_sel[15:0];
            end
            g_y = $signed(g_abs);
        end else begin
            if (q_sel > DIV_W'(32768)) begin
                g_abs = 16'd32768;
            end else begin
                g_abs = q_sel[15:0];
            end
            g_y = $signed(~g_abs + 16'd1);
        end
    end

    // Target gain and slew.
    logic [GW-1:0] t_new, cur_new, floor_g, dn;
    logic [GW:0]   up;

    always_comb begin
        if (r_sil || (r_tpl == '0)) begin
            t_new = '0;
        end else if (r_fixed) begin
            t_new = GW'(r_fixed_gain);
        end else if (r_raw == '0) begin
            t_new = GW'(GMAX);
        end else if (div_q > DIV_W'(GMAX)) begin
            t_new = GW'(GMAX);
        end else if (div_q < DIV_W'(GAIN_ONE)) begin
            t_new = GW'(GAIN_ONE);
        end else begin
            t_new = div_q[GW-1:0];
        end
        floor_g = r_sil ? '0 : GW'(GAIN_ONE);
        up      = {1'b0, r_current} + (GW+1)'(STEP_UP);
        dn      = (r_current > GW'(STEP_DOWN)) ? r_current - GW'(STEP_DOWN) : floor_g;
        if (r_current < t_new) begin
            cur_new = (up < {1'b0, t_new}) ? up[GW-1:0] : t_new;
        end else if (r_current > t_new) begin
            cur_new = (dn > t_new) ? dn : t_new;
        end else begin
            cur_new = r_current;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass     <= 1'b0;
            r_hp_on      <= 1'b1;
            r_fixed      <= 1'b0;
            r_fixed_gain <= GAIN_RESET;
            r_tpl        <= TARGET_PEAK_RST;
            r_qthr       <= QUIET_THR_RST;
            r_qhold      <= QUIET_HOLD_RST;
            r_prev_in    <= '0;
            r_prev_out   <= '0;
            r_primed     <= 1'b0;
            r_lf         <= '0;
            r_lfv        <= 1'b0;
            r_qcnt       <= '0;
            r_sil        <= 1'b0;
            r_raw        <= '0;
            r_scaled     <= '0;
            r_craw       <= '0;
            r_cscaled    <= '0;
            r_active     <= GW'(GAIN_RESET);
            r_previous   <= GW'(GAIN_RESET);
            r_current    <= GW'(GAIN_RESET);
            r_target     <= GW'(GAIN_RESET);
            r_switched   <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_FIRST_GO: begin
                    if (r_in.restart_filter) begin
                        r_prev_in  <= '0;
                        r_prev_out <= '0;
                        r_primed   <= 1'b0;
                        r_lfv      <= 1'b0;
                        r_qcnt     <= '0;
                        r_sil      <= 1'b0;
                    end
                end
                OP_FIRST_DONE: begin
                    r_raw      <= r_sil ? 16'd0 : raw_dec;
                    r_scaled   <= r_sil ? 16'd0 : scl_dec;
                    r_craw     <= '0;
                    r_cscaled  <= '0;
                    r_active   <= r_previous;
                    r_switched <= (r_previous == r_current);
                end
                OP_HP_SUM: begin
                    if (r_hp_on) begin
                        r_prev_in <= r_in.sample_in;
                        if (!r_primed) begin
                            r_prev_out <= '0;
                            r_primed   <= 1'b1;
                        end else begin
                            r_prev_out <= hp_out32;
                        end
                    end
                end
                OP_GATE: begin
                    if (f_abs > {1'b0, r_qthr}) begin
                        r_qcnt <= '0;
                        r_sil  <= 1'b0;
                    end else begin
                        r_qcnt <= q_next;
                        r_sil  <= q_next > {1'b0, r_qhold};
                    end
                    if (!r_in.mute_chunk) begin
                        if (f_abs > r_craw) begin
                            r_craw <= f_abs;
                        end
                        if ((r_active != r_current) && crossed) begin
                            r_active   <= r_current;
                            r_previous <= r_current;
                            r_switched <= 1'b1;
                        end
                    end
                end
                OP_G_OUT: begin
                    if (!r_in.mute_chunk) begin
                        if (g_abs > r_cscaled) begin
                            r_cscaled <= g_abs;
                        end
                        r_lf  <= r_f;
                        r_lfv <= 1'b1;
                    end
                end
                OP_LAST: begin
                    if (r_in.mute_chunk) begin
                        r_lfv <= 1'b0;
                    end else begin
                        if (!r_switched) begin
                            r_previous <= r_current;
                        end
                        if (r_craw > r_raw) begin
                            r_raw <= r_craw;
                        end
                        if (r_cscaled > r_scaled) begin
                            r_scaled <= r_cscaled;
                        end
                    end
                end
                OP_T_DONE: begin
                    r_target  <= t_new;
                    r_current <= cur_new;
                    if (r_sil) begin
                        r_raw    <= '0;
                        r_scaled <= '0;
                    end
                end
                default: begin
                end
            endcase

            // Writes must arrive only while no word is in flight; this is not enforced here.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BYPASS: begin
                        if (i_cfg_data[0] != r_bypass) begin
                            r_prev_in  <= '0;
                            r_prev_out <= '0;
                            r_primed   <= 1'b0;
                            r_lfv      <= 1'b0;
                            r_qcnt     <= '0;
                            r_sil      <= 1'b0;
                        end
                        r_bypass <= i_cfg_data[0];
                    end
                    CFG_HIGHPASS: begin
                        if (i_cfg_data[0] != r_hp_on) begin
                            r_prev_in  <= '0;
                            r_prev_out <= '0;
                            r_primed   <= 1'b0;
                            r_lfv      <= 1'b0;
                            r_qcnt     <= '0;
                            r_sil      <= 1'b0;
                        end
                        r_hp_on <= i_cfg_data[0];
                    end
                    CFG_FIXED_MODE: begin
                        r_fixed <= i_cfg_data[0];
                        if (i_cfg_data[0]) begin
                            r_target <= GW'(r_fixed_gain);
                        end
                    end
                    CFG_FIXED_GAIN: begin
                        r_fixed_gain <= i_cfg_data;
                        if (r_fixed) begin
                            r_target <= GW'(i_cfg_data);
                        end
                    end
                    CFG_TARGET_PEAK: r_tpl   <= i_cfg_data[14:0];
                    CFG_QUIET_THR:   r_qthr  <= i_cfg_data[14:0];
                    CFG_QUIET_HOLD:  r_qhold <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD:  r_in   <= i_in_word;
            OP_HP_MUL: r_prod <= hp_mul;
            OP_G_MUL: r_prod <= DIV_W'(g_mul);
            OP_HP_SUM: begin
                if (!r_hp_on) begin
                    r_f <= r_in.sample_in;
                end else if (!r_primed) begin
                    r_f <= '0;
                end else begin
                    r_f <= hp_out16;
                end
            end
            OP_G_OUT: r_y <= r_in.mute_chunk ? 16'sd0 : g_y;
            OP_OUT: begin
                r_out.sample_out   <= r_bypass ? r_in.sample_in : r_y;
                r_out.gain_now     <= r_current[15:0];
                r_out.raw_peak_out <= r_sil ? 16'd0 : r_raw;
                r_out.silence_flag <= r_sil;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.bypass    = r_bypass;
    assign o_stat.first     = r_in.chunk_first;
    assign o_stat.last      = r_in.chunk_last;
    assign o_stat.mute      = r_in.mute_chunk;
    assign o_stat.div_busy  = div_busy;
    assign o_stat.tdiv_need = !r_sil && (r_tpl != '0) && !r_fixed && (r_raw != '0);
    assign o_out_word       = r_out;

    a_unprimed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_primed |-> (r_prev_out == '0))
        else $error("filter holds output history while unprimed");

endmodule

>>> rtl/core/mha_ctrl.sv
// Controller: sequences the datapath operations for one word and runs the handshakes.
module mha_ctrl #(
    parameter int GAIN_ONE = 8192
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  mha_pkg::t_stat i_stat,
    output mha_pkg::t_cmd  o_cmd
);
    import mha_pkg::*;

    localparam bit POW2 = (GAIN_ONE == (1 << $clog2(GAIN_ONE)));

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_HPMUL  = 5'd1;
    localparam logic [4:0] S_FIRST  = 5'd2;
    localparam logic [4:0] S_FWAIT  = 5'd3;
    localparam logic [4:0] S_HPDIV  = 5'd4;
    localparam logic [4:0] S_HPWAIT = 5'd5;
    localparam logic [4:0] S_HPSUM  = 5'd6;
    localparam logic [4:0] S_GATE   = 5'd7;
    localparam logic [4:0] S_GMUL   = 5'd8;
    localparam logic [4:0] S_GDIV   = 5'd9;
    localparam logic [4:0] S_GWAIT  = 5'd10;
    localparam logic [4:0] S_GOUT   = 5'd11;
    localparam logic [4:0] S_LAST   = 5'd12;
    localparam logic [4:0] S_LCHK   = 5'd13;
    localparam logic [4:0] S_LWAIT  = 5'd14;
    localparam logic [4:0] S_LDONE  = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;

    logic [4:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       r_first_done, n_first_done;
    logic       out_free;

    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_first_done = r_first_done;
        o_cmd.op     = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op     = OP_LOAD;
                    n_first_done = 1'b0;
                    n_state      = S_HPMUL;
                end
            end
            S_HPMUL: begin
                o_cmd.op = OP_HP_MUL;
                if (i_stat.bypass) begin
                    n_state = S_OUT;
                end else if (i_stat.first && !r_first_done) begin
                    n_state = S_FIRST;
                end else begin
                    n_state = POW2 ? S_HPSUM : S_HPDIV;
                end
            end
            S_FIRST: begin
                o_cmd.op = OP_FIRST_GO;
                n_state  = S_FWAIT;
            end
            S_FWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op     = OP_FIRST_DONE;
                    n_first_done = 1'b1;
                    n_state      = S_HPMUL;
                end
            end
            S_HPDIV: begin
                o_cmd.op = OP_HP_GO;
                n_state  = S_HPWAIT;
            end
            S_HPWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_HPSUM;
                end
            end
            S_HPSUM: begin
                o_cmd.op = OP_HP_SUM;
                n_state  = S_GATE;
            end
            S_GATE: begin
                o_cmd.op = OP_GATE;
                n_state  = S_GMUL;
            end
            S_GMUL: begin
                o_cmd.op = OP_G_MUL;
                n_state  = POW2 ? S_GOUT : S_GDIV;
            end
            S_GDIV: begin
                o_cmd.op = OP_G_GO;
                n_state  = S_GWAIT;
            end
            S_GWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_GOUT;
                end
            end
            S_GOUT: begin
                o_cmd.op = OP_G_OUT;
                n_state  = i_stat.last ? S_LAST : S_OUT;
            end
            S_LAST: begin
                o_cmd.op = OP_LAST;
                n_state  = i_stat.mute ? S_OUT : S_LCHK;
            end
            S_LCHK: begin
                if (i_stat.tdiv_need) begin
                    o_cmd.op = OP_T_GO;
                    n_state  = S_LWAIT;
                end else begin
                    n_state = S_LDONE;
                end
            end
            S_LWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_LDONE;
                end
            end
            S_LDONE: begin
                o_cmd.op = OP_T_DONE;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if ((r_state == S_OUT) && out_free) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_first_done <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ovalid     <= n_ovalid;
            r_first_done <= n_first_done;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted word did not start processing");

    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output word raised outside the output step");

    a_out_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("pending output word lost");

endmodule

>>> tb/sv/mic_highpass_agc_top_tb.sv
// Self-checking testbench for the microphone high-pass and gain control block.
`timescale 1ns / 100ps

module mic_highpass_agc_top_tb;
    import mha_pkg::*;

    localparam int GAIN_ONE  = 8192;
    localparam int MAX_CHUNK = 1024;
    localparam int HP_COEF   = (8151 * GAIN_ONE) / 8192;
    localparam int GAIN_MAX  = 5 * GAIN_ONE;
    localparam int STEP_UP   = (GAIN_ONE / 128) * 3;
    localparam int STEP_DOWN = (GAIN_ONE / 128) * 8;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;
    logic      i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;

    mic_highpass_agc_top #(.GAIN_ONE(GAIN_ONE), .MAX_CHUNK(MAX_CHUNK)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Predictor state: a private copy of the block's registers and internal state.
    longint agc_bypass, agc_hp_on, agc_fixed, agc_fixed_gain;
    longint agc_tpeak, agc_qthr, agc_qhold;
    longint hp_x1, hp_y1, last_f, quiet_cnt;
    bit     hp_primed, last_f_ok, silent, switched;
    longint raw_pk, scl_pk, ch_raw_pk, ch_scl_pk;
    longint act_gain, prev_gain, cur_gain, tgt_gain;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        errors;
    int        words_checked;
    int        chunks_sent;

    function automatic longint sat_to(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Truncating division toward zero, matching C semantics for signed values.
    function automatic longint div_trunc(longint a, longint b);
        longint q;
        q = abs_of(a) / b;
        return (a < 0) ? -q : q;
    endfunction

    function automatic void clear_filter_state();
        hp_x1 = 0;
        hp_y1 = 0;
        hp_primed = 0;
        last_f_ok = 0;
    endfunction

    function automatic void clear_gate_state();
        quiet_cnt = 0;
        silent = 0;
    endfunction

    function automatic void agc_reset();
        agc_bypass = 0; agc_hp_on = 1; agc_fixed = 0; agc_fixed_gain = 12288;
        agc_tpeak = 24575; agc_qthr = 65; agc_qhold = 8000;
        clear_filter_state();
        clear_gate_state();
        last_f = 0;
        raw_pk = 0; scl_pk = 0; ch_raw_pk = 0; ch_scl_pk = 0;
        act_gain = 12288; prev_gain = 12288; cur_gain = 12288; tgt_gain = 12288;
        switched = 0;
    endfunction

    function automatic void agc_write(logic [CFG_IDX_W-1:0] idx, longint v);
        case (idx)
            CFG_BYPASS: begin
                if ((v & 1) != agc_bypass) begin
                    clear_filter_state();
                    clear_gate_state();
                end
                agc_bypass = v & 1;
            end
            CFG_HIGHPASS: begin
                if ((v & 1) != agc_hp_on) begin
                    clear_filter_state();
                    clear_gate_state();
                end
                agc_hp_on = v & 1;
            end
            CFG_FIXED_MODE: begin
                agc_fixed = v & 1;
                if (agc_fixed != 0) tgt_gain = agc_fixed_gain;
            end
            CFG_FIXED_GAIN: begin
                agc_fixed_gain = v;
                if (agc_fixed != 0) tgt_gain = v;
            end
            CFG_TARGET_PEAK: agc_tpeak = v & 16'h7FFF;
            CFG_QUIET_THR:   agc_qthr = v & 16'h7FFF;
            CFG_QUIET_HOLD:  agc_qhold = v;
            default: ;
        endcase
    endfunction

    function automatic longint peak_after_decay(longint pk, longint len);
        longint d;
        longint q;
        d = 1;
        if (len > MAX_CHUNK) len = MAX_CHUNK;
        if (len > 0) begin
            q = (32767 * len * 2) / (16000 * 3);
            if (q > d) d = q;
        end
        return (d >= pk) ? 0 : pk - d;
    endfunction

    function automatic longint highpass_step(longint x);
        longint y;
        if (agc_hp_on == 0) return x;
        if (!hp_primed) begin
            hp_x1 = x;
            hp_y1 = 0;
            hp_primed = 1;
            return 0;
        end
        y = x - hp_x1 + div_trunc(HP_COEF * hp_y1, GAIN_ONE);
        hp_x1 = x;
        hp_y1 = sat_to(y, -64'sd2147483648, 64'sd2147483647);
        return sat_to(hp_y1, -32768, 32767);
    endfunction

    function automatic void choose_target();
        longint g;
        if (silent || agc_tpeak == 0) begin
            tgt_gain = 0;
        end else if (agc_fixed != 0) begin
            tgt_gain = agc_fixed_gain;
        end else if (raw_pk == 0) begin
            tgt_gain = GAIN_MAX;
        end else begin
            g = (agc_tpeak * GAIN_ONE + raw_pk / 2) / raw_pk;
            tgt_gain = sat_to(g, GAIN_ONE, GAIN_MAX);
        end
    endfunction

    function automatic void slew_gain();
        longint n;
        longint floor_g;
        if (cur_gain < tgt_gain) begin
            n = cur_gain + STEP_UP;
            cur_gain = (n < tgt_gain) ? n : tgt_gain;
        end else if (cur_gain > tgt_gain) begin
            floor_g = silent ? 0 : GAIN_ONE;
            n = (cur_gain > STEP_DOWN) ? cur_gain - STEP_DOWN : floor_g;
            cur_gain = (n > tgt_gain) ? n : tgt_gain;
        end
    endfunction

    // Computes the output word for one accepted input word and advances the state.
    function automatic t_out_word agc_process(t_in_word w);
        t_out_word r;
        longint x, f, y, m;
        bit crossed;
        x = longint'(w.sample_in);
        y = x;
        if (agc_bypass == 0) begin
            if (w.chunk_first) begin
                if (w.restart_filter) begin
                    clear_filter_state();
                    clear_gate_state();
                end
                raw_pk = peak_after_decay(raw_pk, w.chunk_length);
                scl_pk = peak_after_decay(scl_pk, w.chunk_length);
                if (silent) begin
                    raw_pk = 0;
                    scl_pk = 0;
                end
                ch_raw_pk = 0;
                ch_scl_pk = 0;
                act_gain = prev_gain;
                switched = (act_gain == cur_gain);
            end
            f = highpass_step(x);
            // Silence gate: the counter saturates one above the hold.
            if (abs_of(f) > agc_qthr) begin
                clear_gate_state();
            end else begin
                if (quiet_cnt <= agc_qhold) quiet_cnt++;
                silent = quiet_cnt > agc_qhold;
            end
            if (w.mute_chunk) begin
                y = 0;
            end else begin
                m = abs_of(f);
                if (m > ch_raw_pk) ch_raw_pk = m;
                crossed = (f == 0) || (last_f_ok &&
                          ((last_f < 0 && f > 0) || (last_f > 0 && f < 0)));
                if (act_gain != cur_gain && crossed) begin
                    act_gain = cur_gain;
                    prev_gain = cur_gain;
                    switched = 1;
                end
                y = sat_to(div_trunc(f * act_gain, GAIN_ONE), -32768, 32767);
                m = abs_of(y);
                if (m > ch_scl_pk) ch_scl_pk = m;
                last_f = f;
                last_f_ok = 1;
            end
            if (w.chunk_last) begin
                if (w.mute_chunk) begin
                    last_f_ok = 0;
                end else begin
                    if (!switched) prev_gain = cur_gain;
                    if (ch_raw_pk > raw_pk) raw_pk = ch_raw_pk;
                    if (ch_scl_pk > scl_pk) scl_pk = ch_scl_pk;
                    choose_target();
                    slew_gain();
                    if (silent) begin
                        raw_pk = 0;
                        scl_pk = 0;
                    end
                end
            end
        end
        r.sample_out   = y[15:0];
        r.gain_now     = cur_gain[15:0];
        r.raw_peak_out = silent ? 16'd0 : raw_pk[15:0];
        r.silence_flag = silent;
        return r;
    endfunction

    // Idle about a quarter of the cycles, except inside the calm window.
    bit calm;
    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 25);
    endfunction

    // Driver: presents queued words and keeps a word steady until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_words.push_back(agc_process(i_in_word));
                if (pending_words.size() > 0 && !idle_now()) begin
                    i_in_word  <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid && pending_words.size() > 0 && !idle_now()) begin
                i_in_word  <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // Monitor: compares each accepted output word with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected output word %h", $time, o_out_word);
                    errors++;
                end else begin
                    exp_w = expected_words.pop_front();
                    words_checked++;
                    if (o_out_word.sample_out !== exp_w.sample_out) begin
                        $display("%0t: sample_out expected %0d actual %0d", $time,
                                 exp_w.sample_out, o_out_word.sample_out);
                        errors++;
                    end
                    if (o_out_word.gain_now !== exp_w.gain_now) begin
                        $display("%0t: gain_now expected %0d actual %0d", $time,
                                 exp_w.gain_now, o_out_word.gain_now);
                        errors++;
                    end
                    if (o_out_word.raw_peak_out !== exp_w.raw_peak_out) begin
                        $display("%0t: raw_peak_out expected %0d actual %0d", $time,
                                 exp_w.raw_peak_out, o_out_word.raw_peak_out);
                        errors++;
                    end
                    if (o_out_word.silence_flag !== exp_w.silence_flag) begin
                        $display("%0t: silence_flag expected %0d actual %0d", $time,
                                 exp_w.silence_flag, o_out_word.silence_flag);
                        errors++;
                    end
                end
            end
            i_out_ready <= !idle_now();
        end
    end

    // Builds one input word from its fields.
    function automatic t_in_word make_word(longint s, bit first, bit last, longint len,
                                           bit mute, bit restart);
        t_in_word w;
        w.sample_in      = s[15:0];
        w.chunk_first    = first;
        w.chunk_last     = last;
        w.chunk_length   = len[10:0];
        w.mute_chunk     = mute;
        w.restart_filter = restart;
        return w;
    endfunction

    // Queues one well-formed chunk. Mostly small lengths; the flag field carries the
    // declared length, which may differ from the number of words actually sent.
    task automatic queue_chunk(int n, int style);
        longint amp, dc, s, len;
        bit mute, restart;
        int k;
        amp = (style == 0) ? $urandom_range(0, 40) :
              ((style == 1) ? $urandom_range(0, 32767) : $urandom_range(0, 3000));
        dc = $signed($urandom_range(0, 65535)) - 32768;
        dc = dc / 4;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047) : n;
        mute = ($urandom_range(0, 9) == 0);
        restart = ($urandom_range(0, 7) == 0);
        for (k = 0; k < n; k++) begin
            s = dc + $signed($urandom_range(0, 2 * amp)) - amp;
            if ($urandom_range(0, 30) == 0) s = longint'($urandom_range(0, 65535)) - 32768;
            s = sat_to(s, -32768, 32767);
            pending_words.push_back(make_word(s, k == 0, k == n - 1, len,
                                              mute || ($urandom_range(0, 40) == 0),
                                              restart || ($urandom_range(0, 30) == 0)));
        end
        chunks_sent++;
    endtask

    // Waits for all queued words to be accepted and answered, then lets the
    // block finish any trailing division before the next register write.
    task automatic drain_block();
        while (pending_words.size() > 0 || i_in_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        agc_write(idx, v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int phase, k, total;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_in_word   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_BYPASS;
        i_cfg_data  = '0;
        errors      = 0;
        words_checked = 0;
        chunks_sent = 0;
        calm        = 0;
        agc_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: field extremes, muted samples and chunk end, restart with
        // and without first, length zero and above the maximum, marks out of order.
        pending_words.push_back(make_word(32767, 1, 0, 0, 0, 0));
        pending_words.push_back(make_word(-32768, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(32767, 0, 0, 2047, 0, 1));
        pending_words.push_back(make_word(-32768, 0, 1, 1024, 0, 0));
        pending_words.push_back(make_word(0, 1, 0, 2047, 0, 1));
        pending_words.push_back(make_word(1, 0, 0, 1, 1, 0));
        pending_words.push_back(make_word(-1, 0, 1, 1, 1, 0));
        pending_words.push_back(make_word(20000, 1, 1, 1, 0, 0));
        pending_words.push_back(make_word(-20000, 0, 1, 3, 0, 0));
        pending_words.push_back(make_word(5, 1, 0, 1024, 0, 0));
        pending_words.push_back(make_word(-7, 1, 0, 1025, 0, 1));
        pending_words.push_back(make_word(0, 0, 1, 5, 0, 0));
        drain_block();

        // Register phases, extremes included; bypass and high-pass toggles clear state.
        total = 0;
        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_QUIET_HOLD, 16'd20);
                    write_reg(CFG_QUIET_THR, 15'd65);
                end
                1: begin
                    write_reg(CFG_FIXED_GAIN, 16'd40960);
                    write_reg(CFG_FIXED_MODE, 16'd1);
                end
                2: begin
                    write_reg(CFG_FIXED_GAIN, 16'd8192);
                    write_reg(CFG_HIGHPASS, 16'd0);
                    write_reg(CFG_QUIET_HOLD, 16'd0);
                end
                3: begin
                    write_reg(CFG_FIXED_MODE, 16'd0);
                    write_reg(CFG_TARGET_PEAK, 15'd0);
                    write_reg(CFG_QUIET_THR, 15'd32767);
                    write_reg(CFG_QUIET_HOLD, 16'd65535);
                end
                4: begin
                    write_reg(CFG_TARGET_PEAK, 15'd32767);
                    write_reg(CFG_QUIET_THR, 15'd0);
                    write_reg(CFG_HIGHPASS, 16'd1);
                end
                5: begin
                    write_reg(CFG_BYPASS, 16'd1);
                end
                6: begin
                    write_reg(CFG_BYPASS, 16'd0);
                    write_reg(CFG_TARGET_PEAK, 15'd24575);
                    write_reg(CFG_QUIET_THR, 15'd200);
                    write_reg(CFG_QUIET_HOLD, 16'd40);
                    calm = 1;
                end
                7: begin
                    calm = 0;
                    write_reg(CFG_TARGET_PEAK, 16'($urandom_range(1, 32767)));
                    write_reg(CFG_FIXED_GAIN, 16'($urandom_range(8192, 40960)));
                end
                8: begin
                    write_reg(CFG_FIXED_MODE, 16'd1);
                    write_reg(CFG_QUIET_HOLD, 16'd8000);
                end
                default: begin
                    write_reg(CFG_FIXED_MODE, 16'd0);
                    write_reg(CFG_QUIET_THR, 15'd65);
                end
            endcase
            while (total < (phase + 1) * 195) begin
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) :
                    $urandom_range(1, 12);
                queue_chunk(k, $urandom_range(0, 2));
                // Occasional stray word with every field random.
                if ($urandom_range(0, 9) == 0) begin
                    pending_words.push_back(t_in_word'(31'($urandom())));
                    total++;
                end
                total += k;
            end
            drain_block();
        end
        $display("Covered %0d chunks over ten register settings, %0d words checked.",
                 chunks_sent, words_checked);
        $display("Included bypass, fixed gain, silence gate and muted chunk ends.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout waiting for output words");
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mha_pkg.sv
rtl/core/mha_div.sv
rtl/core/mha_datapath.sv
rtl/core/mha_ctrl.sv
rtl/core/mic_highpass_agc_top.sv
tb/sv/mic_highpass_agc_top_tb.sv
